// ----- rtl/tensor_tile_burst_address_generator_defines.svh -----
// Assertion macros shared by the tensor tile burst address generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TENSOR_TILE_BURST_ADDRESS_GENERATOR_DEFINES_SVH
`define TENSOR_TILE_BURST_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define TTTBAG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds out of reset.
`define TTTBAG_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TTTBAG_ASSERT(label, clk, rstn, prop, msg)
`define TTTBAG_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/tttbag_pkg.sv -----
// Shared types and constants for the tensor tile burst address generator.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package tttbag_pkg;

    localparam int ADDR_W      = 40;
    localparam int IDX_W       = 32;
    localparam int REG_W       = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int LEVELS      = 4;

    // Counter levels, innermost first
    localparam int LVL_INNER  = 0;
    localparam int LVL_THIRD  = 1;
    localparam int LVL_SECOND = 2;
    localparam int LVL_OUTER  = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_ADDRESS      = 3'd0,
        REG_TILE_COUNT_OUTER  = 3'd1,
        REG_TILE_COUNT_SECOND = 3'd2,
        REG_TILE_COUNT_THIRD  = 3'd3,
        REG_TILE_COUNT_INNER  = 3'd4,
        REG_FULL_DIM_SECOND   = 3'd5,
        REG_FULL_DIM_THIRD    = 3'd6,
        REG_FULL_DIM_INNER    = 3'd7
    } cfg_reg_t;

    localparam logic       OP_START     = 1'b0;
    localparam logic       OP_NEXT      = 1'b1;
    localparam logic [1:0] KIND_OUTPUT  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic       ACTION_STORE = 1'b1;

    // Per-element control that rides along with the counter snapshot
    typedef struct packed {
        logic write_req;
        logic first;
        logic last;
    } item_ctl_t;

endpackage

// ----- rtl/tttbag_stride.sv -----
// Stride products for the tensor tile walk, rebuilt after each register write.
// Depends on tttbag_pkg; reports when the products are settled.
`timescale 1ns / 1ps

module tttbag_stride
    import tttbag_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_write,
    input  logic [REG_W-1:0] full_dim_second,
    input  logic [REG_W-1:0] full_dim_third,
    input  logic [REG_W-1:0] full_dim_inner,
    output logic [IDX_W-1:0] stride_outer,
    output logic [IDX_W-1:0] stride_second,
    output logic [IDX_W-1:0] stride_third,
    output logic             settled
);

    localparam int               SETTLE_W      = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

    logic [IDX_W-1:0]    s0_reg;
    logic [IDX_W-1:0]    s1_reg;
    logic [IDX_W-1:0]    s2_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    // Two multiplier stages: third*inner, then second*(third*inner)
    always_ff @(posedge aclk) begin
        s2_reg <= IDX_W'(full_dim_inner);
        s1_reg <= IDX_W'(full_dim_third) * IDX_W'(full_dim_inner);
        s0_reg <= IDX_W'(full_dim_second) * s1_reg;
    end

    always_comb begin
        settle_next = settle_reg;
        if (cfg_write) begin
            settle_next = SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign stride_outer  = s0_reg;
    assign stride_second = s1_reg;
    assign stride_third  = s2_reg;
    assign settled       = (settle_reg == '0);

endmodule

// ----- rtl/tttbag_walker.sv -----
// Tile walker: start and next handling, four nested counters, last detection.
// Depends on tttbag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tensor_tile_burst_address_generator_defines.svh"

module tttbag_walker
    import tttbag_pkg::*;
#(
    parameter int COUNT_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic                               op,
    input  logic [1:0]                         data_kind,
    input  logic                               action,
    input  logic [IDX_W-1:0]                   tile_offset,
    input  logic [LEVELS-1:0][REG_W-1:0]       ext,
    output logic                               issue,
    output item_ctl_t                          ctl,
    output logic [LEVELS-1:0][COUNT_BITS-1:0]  cnt,
    output logic [IDX_W-1:0]                   offset
);

    localparam int CMP_W = (COUNT_BITS + 1 > REG_W) ? COUNT_BITS + 1 : REG_W;
    localparam logic [CMP_W-1:0] CAP = {{(CMP_W-1){1'b0}}, 1'b1} << COUNT_BITS;

    logic [LEVELS-1:0][COUNT_BITS-1:0] cnt_reg;
    logic [LEVELS-1:0][COUNT_BITS-1:0] cnt_next;
    logic [IDX_W-1:0]                  saved_offset_reg;
    logic [IDX_W-1:0]                  saved_offset_next;
    logic                              write_mode_reg;
    logic                              write_mode_next;
    logic                              tile_active_reg;
    logic                              tile_active_next;
    logic                              prev_valid_reg;
    logic                              prev_valid_next;

    logic [LEVELS-1:0]      at_end;
    logic [LEVELS-1:0]      ext_zero;
    logic [LEVELS:0]        carry;
    logic [LEVELS-1:0][COUNT_BITS-1:0] cnt_step;
    logic                   tile_last;
    logic                   any_zero;
    logic [CMP_W-1:0]       cnt_inc [LEVELS];

    // Extents above the counter range saturate at 2^COUNT_BITS
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            cnt_inc[l]  = CMP_W'(cnt_reg[l]) + CMP_W'(1);
            at_end[l]   = (cnt_inc[l] >= CMP_W'(ext[l])) || (cnt_inc[l] >= CAP);
            ext_zero[l] = (ext[l] == '0);
        end
    end

    // Ripple carry from the innermost counter outward
    always_comb begin
        carry[0] = 1'b1;
        for (int l = 0; l < LEVELS; l++) begin
            carry[l+1] = carry[l] && at_end[l];
            if (!carry[l]) begin
                cnt_step[l] = cnt_reg[l];
            end else if (at_end[l]) begin
                cnt_step[l] = '0;
            end else begin
                cnt_step[l] = cnt_reg[l] + COUNT_BITS'(1);
            end
        end
    end

    assign tile_last = &at_end;
    assign any_zero  = |ext_zero;
    assign issue     = accept && (op == OP_NEXT) && tile_active_reg && !any_zero;

    always_comb begin
        cnt_next          = cnt_reg;
        saved_offset_next = saved_offset_reg;
        write_mode_next   = write_mode_reg;
        tile_active_next  = tile_active_reg;
        prev_valid_next   = prev_valid_reg;
        if (accept) begin
            if (op == OP_START) begin
                cnt_next          = '0;
                saved_offset_next = tile_offset;
                write_mode_next   = (data_kind == KIND_OUTPUT) && (action == ACTION_STORE);
                tile_active_next  = (data_kind != KIND_UNKNOWN);
                prev_valid_next   = 1'b0;
            end else if (tile_active_reg) begin
                if (any_zero) begin
                    // empty tile: end it without a beat
                    tile_active_next = 1'b0;
                end else begin
                    cnt_next        = cnt_step;
                    prev_valid_next = 1'b1;
                    if (tile_last) begin
                        tile_active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            write_mode_reg  <= 1'b0;
            tile_active_reg <= 1'b0;
            prev_valid_reg  <= 1'b0;
        end else begin
            cnt_reg         <= cnt_next;
            write_mode_reg  <= write_mode_next;
            tile_active_reg <= tile_active_next;
            prev_valid_reg  <= prev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        saved_offset_reg <= saved_offset_next;
    end

    assign ctl.write_req = write_mode_reg;
    assign ctl.first     = !prev_valid_reg;
    assign ctl.last      = tile_last;
    assign cnt           = cnt_reg;
    assign offset        = saved_offset_reg;

    `TTTBAG_ASSERT(a_last_ends_tile, aclk, aresetn, (issue && tile_last) |=> !tile_active_reg, "tile still active after last element")
    `TTTBAG_ASSERT(a_start_clears, aclk, aresetn, (accept && (op == OP_START)) |=> ((cnt_reg == '0) && !prev_valid_reg), "start did not clear the walk")
    `TTTBAG_ASSERT(a_issue_marks_prev, aclk, aresetn, issue |=> prev_valid_reg, "issued element not recorded")

endmodule

// ----- rtl/tttbag_addr_pipe.sv -----
// Address pipeline: stride products, index sum, byte address, burst
// alignment and duplicate suppression. Depends on tttbag_pkg and the macro header.
`timescale 1ns / 1ps
`include "tensor_tile_burst_address_generator_defines.svh"

module tttbag_addr_pipe
    import tttbag_pkg::*;
#(
    parameter int COUNT_BITS    = 12,
    parameter int ELEMENT_BYTES = 4,
    parameter int BURST_SHIFT   = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  item_ctl_t                         in_ctl,
    input  logic [LEVELS-1:0][COUNT_BITS-1:0] in_cnt,
    input  logic [IDX_W-1:0]                  in_offset,
    input  logic [ADDR_W-1:0]                 base_address,
    input  logic [IDX_W-1:0]                  stride_outer,
    input  logic [IDX_W-1:0]                  stride_second,
    input  logic [IDX_W-1:0]                  stride_third,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ADDR_W-1:0]                 m_burst_address,
    output logic                              m_write_req,
    output logic                              m_request_valid,
    output logic                              m_last
);

    localparam logic [ADDR_W-1:0] BURST_MASK =
        ~((ADDR_W'(1) << BURST_SHIFT) - ADDR_W'(1));

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en2, en3, en4;

    logic [LEVELS-1:0][COUNT_BITS-1:0] cnt1_reg;
    logic [IDX_W-1:0]                  off1_reg;
    item_ctl_t                         ctl1_reg;
    logic [LEVELS-1:0][IDX_W-1:0]      term2_reg;
    logic [IDX_W-1:0]                  off2_reg;
    item_ctl_t                         ctl2_reg;
    logic [IDX_W-1:0]                  idx3_reg;
    item_ctl_t                         ctl3_reg;
    logic [ADDR_W-1:0]                 burst_reg;
    logic                              write_req_reg;
    logic                              request_valid_reg;
    logic                              last_reg;
    logic [ADDR_W-1:0]                 prev_burst_reg;

    logic [ADDR_W-1:0] byte_addr;
    logic [ADDR_W-1:0] aligned_addr;

    // A stage may load when it is empty or its contents move on
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign in_ready = !v1_reg || en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign byte_addr    = base_address + ADDR_W'(idx3_reg) * ADDR_W'(ELEMENT_BYTES);
    assign aligned_addr = byte_addr & BURST_MASK;

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cnt1_reg <= in_cnt;
            off1_reg <= in_offset;
            ctl1_reg <= in_ctl;
        end
        if (en2 && v1_reg) begin
            term2_reg[LVL_INNER]  <= IDX_W'(cnt1_reg[LVL_INNER]);
            term2_reg[LVL_THIRD]  <= IDX_W'(IDX_W'(cnt1_reg[LVL_THIRD]) * stride_third);
            term2_reg[LVL_SECOND] <= IDX_W'(IDX_W'(cnt1_reg[LVL_SECOND]) * stride_second);
            term2_reg[LVL_OUTER]  <= IDX_W'(IDX_W'(cnt1_reg[LVL_OUTER]) * stride_outer);
            off2_reg              <= off1_reg;
            ctl2_reg              <= ctl1_reg;
        end
        if (en3 && v2_reg) begin
            // index wraps at 32 bits
            idx3_reg <= off2_reg + term2_reg[LVL_OUTER] + term2_reg[LVL_SECOND]
                      + term2_reg[LVL_THIRD] + term2_reg[LVL_INNER];
            ctl3_reg <= ctl2_reg;
        end
        if (en4 && v3_reg) begin
            burst_reg         <= aligned_addr;
            write_req_reg     <= ctl3_reg.write_req;
            request_valid_reg <= ctl3_reg.first || (aligned_addr != prev_burst_reg);
            last_reg          <= ctl3_reg.last;
            prev_burst_reg    <= aligned_addr;
        end
    end

    assign m_tvalid        = v4_reg;
    assign m_burst_address = burst_reg;
    assign m_write_req     = write_req_reg;
    assign m_request_valid = request_valid_reg;
    assign m_last          = last_reg;

    `TTTBAG_ASSERT(a_first_requested, aclk, aresetn, (v3_reg && en4 && ctl3_reg.first) |=> request_valid_reg, "first address of a tile suppressed")
    `TTTBAG_ASSERT(a_prev_tracks_out, aclk, aresetn, (v3_reg && en4) |=> (prev_burst_reg == burst_reg), "previous burst out of step with output")
    `TTTBAG_ASSERT_NEVER(a_burst_aligned, aclk, aresetn, v4_reg && ((burst_reg & ~BURST_MASK) != '0), "output address not burst aligned")

endmodule

// ----- rtl/tensor_tile_burst_address_generator.sv -----
// Tensor tile burst address generator: config registers, walker, stride and
// address pipeline. Depends on tttbag_pkg, tttbag_stride, tttbag_walker, tttbag_addr_pipe.
`timescale 1ns / 1ps

// Walks a four-level tile inside a stored tensor and issues one burst-aligned
// byte address per "next" beat. A beat is taken every cycle while s_tready is
// high; each result passes through capture, stride products, index sum and
// address add with duplicate check, and the four-entry pipeline keeps taking
// beats while a result waits on m_tready until every stage holds an element.
// Start beats, beats outside an active tile and beats that meet a zero extent
// produce no result. After each register write s_tready stays low while the
// tensor strides pass through the two registered multipliers of the stride
// unit; the register channel itself is always ready.

module tensor_tile_burst_address_generator
    import tttbag_pkg::*;
#(
    parameter int ELEMENT_BYTES = 4,
    parameter int BURST_SHIFT   = 6,
    parameter int COUNT_BITS    = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] tile_offset
    input  logic [3:0]             s_tuser,   // [0] op, [2:1] data_kind, [3] action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // [39:0] burst_address
    output logic [1:0]             m_tuser,   // [0] write_req, [1] request_valid
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    logic [ADDR_W-1:0]                 base_address_reg;
    logic [LEVELS-1:0][REG_W-1:0]      ext_reg;
    logic [REG_W-1:0]                  full_dim_second_reg;
    logic [REG_W-1:0]                  full_dim_third_reg;
    logic [REG_W-1:0]                  full_dim_inner_reg;

    logic                              cfg_write;
    logic                              accept;
    logic                              settled;
    logic                              pipe_ready;
    logic                              issue;
    item_ctl_t                         item_ctl;
    logic [LEVELS-1:0][COUNT_BITS-1:0] item_cnt;
    logic [IDX_W-1:0]                  item_offset;
    logic [IDX_W-1:0]                  stride_outer;
    logic [IDX_W-1:0]                  stride_second;
    logic [IDX_W-1:0]                  stride_third;
    logic [ADDR_W-1:0]                 out_burst_address;
    logic                              out_write_req;
    logic                              out_request_valid;
    logic                              out_last;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg    <= '0;
            ext_reg             <= {LEVELS{REG_W'(1)}};
            full_dim_second_reg <= REG_W'(1);
            full_dim_third_reg  <= REG_W'(1);
            full_dim_inner_reg  <= REG_W'(1);
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_ADDRESS:      base_address_reg      <= cfg_data;
                REG_TILE_COUNT_OUTER:  ext_reg[LVL_OUTER]    <= cfg_data[REG_W-1:0];
                REG_TILE_COUNT_SECOND: ext_reg[LVL_SECOND]   <= cfg_data[REG_W-1:0];
                REG_TILE_COUNT_THIRD:  ext_reg[LVL_THIRD]    <= cfg_data[REG_W-1:0];
                REG_TILE_COUNT_INNER:  ext_reg[LVL_INNER]    <= cfg_data[REG_W-1:0];
                REG_FULL_DIM_SECOND:   full_dim_second_reg   <= cfg_data[REG_W-1:0];
                REG_FULL_DIM_THIRD:    full_dim_third_reg    <= cfg_data[REG_W-1:0];
                REG_FULL_DIM_INNER:    full_dim_inner_reg    <= cfg_data[REG_W-1:0];
                default:               base_address_reg      <= base_address_reg;
            endcase
        end
    end

    assign s_tready = pipe_ready && settled;
    assign accept   = s_tvalid && s_tready;

    tttbag_stride u_stride (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .full_dim_second (full_dim_second_reg),
        .full_dim_third  (full_dim_third_reg),
        .full_dim_inner  (full_dim_inner_reg),
        .stride_outer    (stride_outer),
        .stride_second   (stride_second),
        .stride_third    (stride_third),
        .settled         (settled)
    );

    tttbag_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (s_tuser[0]),
        .data_kind   (s_tuser[2:1]),
        .action      (s_tuser[3]),
        .tile_offset (s_tdata),
        .ext         (ext_reg),
        .issue       (issue),
        .ctl         (item_ctl),
        .cnt         (item_cnt),
        .offset      (item_offset)
    );

    tttbag_addr_pipe #(
        .COUNT_BITS    (COUNT_BITS),
        .ELEMENT_BYTES (ELEMENT_BYTES),
        .BURST_SHIFT   (BURST_SHIFT)
    ) u_addr_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (issue),
        .in_ready        (pipe_ready),
        .in_ctl          (item_ctl),
        .in_cnt          (item_cnt),
        .in_offset       (item_offset),
        .base_address    (base_address_reg),
        .stride_outer    (stride_outer),
        .stride_second   (stride_second),
        .stride_third    (stride_third),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_burst_address (out_burst_address),
        .m_write_req     (out_write_req),
        .m_request_valid (out_request_valid),
        .m_last          (out_last)
    );

    assign m_tdata = out_burst_address;
    assign m_tuser = {out_request_valid, out_write_req};
    assign m_tlast = out_last;

endmodule

// ----- tb/tttbag_burst_checker.sv -----
// Burst request checker for the tensor tile burst address generator.
// Watches the command, register and request channels and predicts each request.
// Depends on tttbag_pkg.
`timescale 1ns / 1ps

module tttbag_burst_checker
    import tttbag_pkg::*;
#(
    parameter int ELEMENT_BYTES = 4,
    parameter int BURST_SHIFT   = 6,
    parameter int COUNT_BITS    = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] tile_offset
    input  logic [3:0]             s_tuser,   // [0] op, [2:1] data_kind, [3] action
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [39:0]            m_tdata,   // [39:0] burst_address
    input  logic [1:0]             m_tuser,   // [0] write_req, [1] request_valid
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic [ADDR_W-1:0] burst_address;
        logic              write_req;
        logic              request_valid;
        logic              last;
    } burst_req_t;

    localparam int                EXTENT_CAP = 1 << COUNT_BITS;
    localparam logic [ADDR_W-1:0] REG_MASK   = (1 << REG_W) - 1;
    localparam logic [ADDR_W-1:0] BURST_MASK = {ADDR_W{1'b1}} << BURST_SHIFT;

    logic [ADDR_W-1:0]     reg_shadow [2**CFG_INDEX_W];
    logic [COUNT_BITS-1:0] walk_count [LEVELS];
    logic [IDX_W-1:0]      tile_origin;
    logic                  tile_writes;
    logic                  tile_open;
    logic [ADDR_W-1:0]     last_burst;
    logic                  last_burst_known;
    burst_req_t            expected_bursts [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic int clamp_extent(logic [ADDR_W-1:0] v);
        return (v > EXTENT_CAP) ? EXTENT_CAP : int'(v);
    endfunction

    // Apply one command beat; a next beat inside an open tile yields one request.
    task automatic walk_tile_element(input logic [3:0] user, input logic [IDX_W-1:0] offset);
        logic              op;
        logic [1:0]        kind;
        logic              action;
        int                ext [LEVELS];
        logic [IDX_W-1:0]  row, plane, volume, index;
        logic [ADDR_W-1:0] wide_index, addr;
        logic              carry;
        logic              all_end;
        logic              at_end [LEVELS];
        burst_req_t        req;

        op     = user[0];
        kind   = user[2:1];
        action = user[3];
        ext[LVL_OUTER]  = clamp_extent(reg_shadow[REG_TILE_COUNT_OUTER]);
        ext[LVL_SECOND] = clamp_extent(reg_shadow[REG_TILE_COUNT_SECOND]);
        ext[LVL_THIRD]  = clamp_extent(reg_shadow[REG_TILE_COUNT_THIRD]);
        ext[LVL_INNER]  = clamp_extent(reg_shadow[REG_TILE_COUNT_INNER]);

        if (op == OP_START) begin
            foreach (walk_count[l]) walk_count[l] = '0;
            tile_origin      = offset;
            tile_writes      = (kind == KIND_OUTPUT) && (action == ACTION_STORE);
            tile_open        = (kind != KIND_UNKNOWN);
            last_burst_known = 1'b0;
        end else if (!tile_open) begin
            // drop: no tile to walk
        end else if (ext[LVL_OUTER] == 0 || ext[LVL_SECOND] == 0 ||
                     ext[LVL_THIRD] == 0 || ext[LVL_INNER] == 0) begin
            tile_open = 1'b0;
        end else begin
            row    = reg_shadow[REG_FULL_DIM_INNER][IDX_W-1:0];
            plane  = reg_shadow[REG_FULL_DIM_THIRD][IDX_W-1:0] * row;
            volume = reg_shadow[REG_FULL_DIM_SECOND][IDX_W-1:0] * plane;
            index  = tile_origin + walk_count[LVL_OUTER] * volume
                   + walk_count[LVL_SECOND] * plane + walk_count[LVL_THIRD] * row
                   + walk_count[LVL_INNER];
            wide_index = index;
            addr = (reg_shadow[REG_BASE_ADDRESS] + wide_index * ELEMENT_BYTES) & BURST_MASK;

            req.burst_address = addr;
            req.write_req     = tile_writes;
            req.request_valid = !(last_burst_known && addr == last_burst);
            last_burst        = addr;
            last_burst_known  = 1'b1;

            all_end = 1'b1;
            for (int l = LVL_INNER; l <= LVL_OUTER; l++) begin
                at_end[l] = (int'(walk_count[l]) + 1 >= ext[l]);
                all_end   = all_end && at_end[l];
            end
            req.last = all_end;

            // ripple the carry outward from the innermost counter
            carry = 1'b1;
            for (int l = LVL_INNER; l <= LVL_OUTER; l++) begin
                if (carry) begin
                    if (at_end[l]) begin
                        walk_count[l] = '0;
                    end else begin
                        walk_count[l] = walk_count[l] + 1'b1;
                        carry = 1'b0;
                    end
                end
            end
            if (all_end) tile_open = 1'b0;
            expected_bursts.insert(expected_bursts.size(), req);
        end
    endtask

    always @(posedge aclk) begin
        burst_req_t want;
        if (!aresetn) begin
            foreach (reg_shadow[r]) reg_shadow[r] = (r == REG_BASE_ADDRESS) ? '0 : 40'd1;
            foreach (walk_count[l]) walk_count[l] = '0;
            tile_origin      = '0;
            tile_writes      = 1'b0;
            tile_open        = 1'b0;
            last_burst       = '0;
            last_burst_known = 1'b0;
            expected_bursts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bursts.size() == 0) begin
                    $error("unexpected burst request: burst_address %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_bursts.pop_front();
                    if (m_tdata !== want.burst_address) begin
                        $error("burst_address: expected %h, actual %h",
                               want.burst_address, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.write_req) begin
                        $error("write_req: expected %b, actual %b", want.write_req, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.request_valid) begin
                        $error("request_valid: expected %b, actual %b",
                               want.request_valid, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                reg_shadow[cfg_index] = (cfg_index == REG_BASE_ADDRESS) ? cfg_data
                                                                        : (cfg_data & REG_MASK);
            end
            if (s_tvalid && s_tready) walk_tile_element(s_tuser, s_tdata);
        end
        outstanding <= expected_bursts.size();
    end

endmodule

// ----- tb/tensor_tile_burst_address_generator_tb.sv -----
// Top of the tensor tile burst address generator testbench: clock, reset,
// command and register stimulus, request back-pressure and verdict.
// Depends on tttbag_pkg, the block and tttbag_burst_checker.
`timescale 1ns / 1ps

module tensor_tile_burst_address_generator_tb;
    import tttbag_pkg::*;

    localparam int ELEMENT_BYTES = 4;
    localparam int BURST_SHIFT   = 6;
    localparam int COUNT_BITS    = 12;
    localparam int TILE_CAP      = 48;   // cap on tile_length() in the random part
    localparam int PHASES        = 10;
    localparam int PHASE_BEATS   = 150;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;   // [31:0] tile_offset
    logic [3:0]             s_tuser   = '0;   // [0] op, [2:1] data_kind, [3] action
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;          // [39:0] burst_address
    logic [1:0]             m_tuser;          // [0] write_req, [1] request_valid
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    int fail_count;
    int outstanding;

    bit feed_gaps    = 1'b1;
    bit drain_stalls = 1'b1;

    logic [REG_W-1:0] tile_ext [LEVELS];

    always #2 aclk = ~aclk;

    tensor_tile_burst_address_generator #(
        .ELEMENT_BYTES(ELEMENT_BYTES),
        .BURST_SHIFT  (BURST_SHIFT),
        .COUNT_BITS   (COUNT_BITS)
    ) DUT (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    tttbag_burst_checker #(
        .ELEMENT_BYTES(ELEMENT_BYTES),
        .BURST_SHIFT  (BURST_SHIFT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .outstanding
    );

    task automatic send_beat(input logic op, input logic [1:0] kind, input logic action,
                             input logic [31:0] offset);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= offset;
        s_tuser  <= {action, kind, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Fields other than op are don't-care on a next beat; randomize them anyway.
    task automatic walk(input int n);
        repeat (n) send_beat(OP_NEXT, 2'($urandom), 1'($urandom), $urandom());
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [ADDR_W-1:0] v);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        if (r != REG_BASE_ADDRESS) v[ADDR_W-1:REG_W] = noise[ADDR_W-1:REG_W];
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_tile(input logic [REG_W-1:0] o, s, t, i);
        write_reg(REG_TILE_COUNT_OUTER, o);
        write_reg(REG_TILE_COUNT_SECOND, s);
        write_reg(REG_TILE_COUNT_THIRD, t);
        write_reg(REG_TILE_COUNT_INNER, i);
    endtask

    task automatic set_tensor(input logic [ADDR_W-1:0] base, input logic [REG_W-1:0] d2, d3, d4);
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_FULL_DIM_SECOND, d2);
        write_reg(REG_FULL_DIM_THIRD, d3);
        write_reg(REG_FULL_DIM_INNER, d4);
    endtask

    // Hold the command channel until every request has drained, plus pipeline slack.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [REG_W-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return REG_W'($urandom_range(4096, 8191));
        return REG_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [REG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return REG_W'(1);
        return REG_W'($urandom_range(1, 8191));
    endfunction

    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        return $urandom();
    endfunction

    function automatic int tile_length();
        longint n;
        n = 1;
        foreach (tile_ext[l]) begin
            if (tile_ext[l] == 0) return 1;
            n *= (tile_ext[l] > (1 << COUNT_BITS)) ? (1 << COUNT_BITS) : tile_ext[l];
        end
        return (n > TILE_CAP) ? $urandom_range(1, TILE_CAP) : int'(n);
    endfunction

    task automatic load_phase_config(input int phase);
        logic [ADDR_W-1:0] base;
        if (phase == 0) begin
            foreach (tile_ext[l]) tile_ext[l] = REG_W'(1);
            base = '0;
            set_tensor(base, REG_W'(1), REG_W'(1), REG_W'(1));
        end else if (phase == 1) begin
            foreach (tile_ext[l]) tile_ext[l] = '1;
            base = '1;
            set_tensor(base, '1, '1, '1);
        end else begin
            foreach (tile_ext[l]) tile_ext[l] = pick_extent();
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = '1;
                default: base = {$urandom(), $urandom()};
            endcase
            set_tensor(base, pick_dim(), pick_dim(), pick_dim());
        end
        set_tile(tile_ext[LVL_OUTER], tile_ext[LVL_SECOND], tile_ext[LVL_THIRD],
                 tile_ext[LVL_INNER]);
    endtask

    // Request side: random back-pressure per beat.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = drain_stalls ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int beats;
        int len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: one-element tiles, each tensor kind and direction.
        walk(1);
        send_beat(OP_START, KIND_UNKNOWN, ACTION_STORE, '1);
        walk(1);
        send_beat(OP_START, 2'd0, 1'b0, '0);
        walk(2);
        send_beat(OP_START, KIND_OUTPUT, ACTION_STORE, '1);
        walk(1);
        send_beat(OP_START, KIND_OUTPUT, 1'b0, 32'h8000_0000);
        walk(1);
        send_beat(OP_START, 2'd1, ACTION_STORE, 32'h0000_0010);
        walk(1);
        settle();

        // Address wrap at top of memory, duplicate bursts, restart mid-tile.
        set_tensor('1, '1, '1, '1);
        set_tile(REG_W'(1), REG_W'(1), REG_W'(2), REG_W'(4));
        send_beat(OP_START, KIND_OUTPUT, ACTION_STORE, 32'hFFFF_FFF0);
        walk(3);
        send_beat(OP_START, 2'd0, 1'b0, 32'hFFFF_FFFC);
        walk(9);
        settle();

        // Empty tile, then an extent shrunk under a running tile.
        write_reg(REG_TILE_COUNT_THIRD, '0);
        send_beat(OP_START, 2'd1, 1'b0, 32'h0000_1234);
        walk(2);
        settle();
        set_tile(REG_W'(1), REG_W'(1), REG_W'(1), REG_W'(8));
        send_beat(OP_START, KIND_OUTPUT, ACTION_STORE, 32'h0000_0100);
        walk(5);
        settle();
        write_reg(REG_TILE_COUNT_INNER, REG_W'(2));
        walk(2);
        settle();

        // Oversized extent saturates instead of dropping its top bit: the walk runs on.
        feed_gaps    = 1'b0;
        drain_stalls = 1'b0;
        set_tensor(40'h00_1000_0000, REG_W'(3), REG_W'(5), REG_W'(7));
        set_tile(REG_W'(1), REG_W'(1), REG_W'(1), REG_W'(4097));
        send_beat(OP_START, 2'd0, 1'b0, 32'h0000_0040);
        walk(40);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            load_phase_config(phase);
            feed_gaps    = ($urandom_range(0, 3) != 0);
            drain_stalls = ($urandom_range(0, 3) != 0);
            beats = 0;
            while (beats < PHASE_BEATS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_beat(1'($urandom), 2'($urandom), 1'($urandom), $urandom());
                        beats += 1;
                    end
                    1: begin
                        // broken walk: cut short or overrun
                        len = tile_length();
                        len = $urandom_range(0, 1) ? $urandom_range(0, len) : len + 2;
                        send_beat(OP_START, 2'($urandom_range(0, 2)), 1'($urandom),
                                  pick_offset());
                        walk(len);
                        beats += 1 + len;
                    end
                    default: begin
                        len = tile_length();
                        send_beat(OP_START, 2'($urandom_range(0, 2)), 1'($urandom),
                                  pick_offset());
                        walk(len);
                        beats += 1 + len;
                    end
                endcase
                if ($urandom_range(0, 39) == 0) settle();
                if ($urandom_range(0, 29) == 0) feed_gaps = !feed_gaps;
                if ($urandom_range(0, 29) == 0) drain_stalls = !drain_stalls;
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- tensor_tile_burst_address_generator.f -----
+incdir+rtl
rtl/tttbag_pkg.sv
rtl/tttbag_stride.sv
rtl/tttbag_walker.sv
rtl/tttbag_addr_pipe.sv
rtl/tensor_tile_burst_address_generator.sv
tb/tttbag_burst_checker.sv
tb/tensor_tile_burst_address_generator_tb.sv
